[hw/rtl/t2o_pkg.sv]
// Shared types, constants and the 6x8 font for the text to OLED byte stream block.
`timescale 1ns / 1ps

package t2o_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic [7:0] set_x;
    logic [7:0] set_y;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_t;

  // One byte request from the sequencer to the output stage.
  typedef struct packed {
    logic [7:0] cmd;
    logic       is_data;
    logic       last;
    logic [4:0] glyph;
    logic [2:0] gcol;
  } seq_req_t;

  localparam logic       ModeLoad   = 1'b0;
  localparam logic       ModeRender = 1'b1;

  localparam logic [7:0] CmdPage    = 8'hB0;
  localparam logic [3:0] CmdColHi   = 4'h1;
  localparam logic [7:0] GlyphW     = 8'd6;
  localparam logic [7:0] DrawWrap   = 8'd122;  // 128 - glyph width
  localparam logic [7:0] LineWrap   = 8'd120;
  localparam logic [7:0] PageStep   = 8'd2;

  // Byte positions within one character's word sequence.
  localparam logic [3:0] BytePage   = 4'd0;
  localparam logic [3:0] ByteColHi  = 4'd1;
  localparam logic [3:0] ByteColLo  = 4'd2;
  localparam logic [3:0] ByteData0  = 4'd3;
  localparam logic [3:0] ByteLast   = 4'd8;

  function automatic logic [4:0] glyph_index(input logic [7:0] ch);
    logic [4:0] g;
    begin
      g = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) g = 5'(ch - 8'h30) + 5'd1;
      else begin
        case (ch)
          8'h3A:   g = 5'd11;  // ':'
          8'h2E:   g = 5'd12;  // '.'
          8'h43:   g = 5'd13;  // 'C'
          8'h54:   g = 5'd14;  // 'T'
          8'h65:   g = 5'd15;  // 'e'
          8'h6D:   g = 5'd16;  // 'm'
          8'h70:   g = 5'd17;  // 'p'
          default: g = 5'd0;
        endcase
      end
      return g;
    end
  endfunction

  function automatic logic [47:0] font_row(input logic [4:0] g);
    logic [47:0] r;
    begin
      case (g)
        5'd1:    r = 48'h3E_51_49_45_3E_00;
        5'd2:    r = 48'h00_42_7F_40_00_00;
        5'd3:    r = 48'h42_61_51_49_46_00;
        5'd4:    r = 48'h21_41_45_4B_31_00;
        5'd5:    r = 48'h18_14_12_7F_10_00;
        5'd6:    r = 48'h27_45_45_45_39_00;
        5'd7:    r = 48'h3C_4A_49_49_30_00;
        5'd8:    r = 48'h01_71_09_05_03_00;
        5'd9:    r = 48'h36_49_49_49_36_00;
        5'd10:   r = 48'h06_49_49_29_1E_00;
        5'd11:   r = 48'h00_36_36_00_00_00;
        5'd12:   r = 48'h00_00_60_60_00_00;
        5'd13:   r = 48'h3E_41_41_41_22_00;
        5'd14:   r = 48'h01_01_7F_01_01_00;
        5'd15:   r = 48'h38_54_54_54_18_00;
        5'd16:   r = 48'h7C_08_04_04_78_00;
        5'd17:   r = 48'h7C_14_14_14_08_00;
        default: r = 48'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] font_byte(input logic [4:0] g, input logic [2:0] c);
    logic [47:0] r;
    logic [7:0]  b;
    begin
      r = font_row(g);
      case (c)
        3'd0:    b = r[47:40];
        3'd1:    b = r[39:32];
        3'd2:    b = r[31:24];
        3'd3:    b = r[23:16];
        3'd4:    b = r[15:8];
        3'd5:    b = r[7:0];
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

[hw/rtl/t2o_glyph_rom.sv]
// Font ROM with a registered read port, one glyph column per read.
`timescale 1ns / 1ps

module t2o_glyph_rom import t2o_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] glyph,
  input  logic [2:0] gcol,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= font_byte(glyph, gcol);
    end
  end

endmodule

[hw/rtl/t2o_seq.sv]
// Cursor state and per-character byte sequencer.
`timescale 1ns / 1ps

module t2o_seq import t2o_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_t      in_data,
  output logic     in_stall,
  input  logic     advance,
  output logic     emit,
  output seq_req_t req
);

  logic [7:0] cur_col;
  logic [7:0] cur_page;
  logic       busy;
  logic [3:0] cnt;
  logic [4:0] glyph;
  logic [7:0] dcol;
  logic [7:0] dpage;

  logic       fire;
  logic       done;
  logic       accept;
  logic       wrap;
  logic [7:0] step_col;
  logic [7:0] dcol_next;
  logic [7:0] dpage_next;

  assign fire     = busy && advance;
  assign done     = fire && (cnt == ByteLast);
  assign in_stall = busy && !done;
  assign accept   = in_valid && !in_stall;
  assign emit     = busy;

  // Draw position and the advanced cursor for a render word.
  assign wrap       = cur_col > DrawWrap;
  assign dcol_next  = wrap ? 8'd0 : cur_col;
  assign dpage_next = cur_page + {7'd0, wrap};
  assign step_col   = cur_col + GlyphW;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= 4'd0;
      cur_col  <= 8'd0;
      cur_page <= 8'd0;
    end else if (accept) begin
      if (in_data.mode == ModeLoad) begin
        // A load only gets in while idle or on the last word, so drop busy.
        busy     <= 1'b0;
        cur_col  <= in_data.set_x;
        cur_page <= in_data.set_y;
      end else begin
        busy <= 1'b1;
        cnt  <= BytePage;
        if (step_col > LineWrap) begin
          cur_col  <= 8'd0;
          cur_page <= cur_page + PageStep;
        end else begin
          cur_col <= step_col;
        end
      end
    end else if (done) begin
      busy <= 1'b0;
    end else if (fire) begin
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.mode == ModeRender) begin
      glyph <= glyph_index(in_data.char_code);
      dcol  <= dcol_next;
      dpage <= dpage_next;
    end
  end

  always_comb begin
    req.glyph   = glyph;
    req.gcol    = 3'(cnt - ByteData0);
    req.is_data = 1'b1;
    req.last    = (cnt == ByteLast);
    req.cmd     = 8'h00;
    case (cnt)
      BytePage: begin
        req.cmd     = CmdPage + dpage;
        req.is_data = 1'b0;
      end
      ByteColHi: begin
        req.cmd     = {CmdColHi, dcol[7:4]};
        req.is_data = 1'b0;
      end
      ByteColLo: begin
        req.cmd     = {4'h0, dcol[3:0]};
        req.is_data = 1'b0;
      end
      default: begin
        req.cmd = 8'h00;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= ByteLast)
    else $error("byte counter beyond last word");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !in_stall)
    else $error("stall raised while idle");
  a_render_start: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.mode == ModeRender) |=> (busy && cnt == BytePage))
    else $error("render word did not start sequence");
`endif

endmodule

[hw/rtl/text_to_oled_byte_stream_top.sv]
// Top level: sequencer, font ROM and output register of the text to OLED byte stream.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_data): mode 0 loads the cursor
//   from set_x / set_y and produces nothing; mode 1 renders char_code.
//   Output channel (out_valid / out_stall / out_data): each rendered
//   character yields nine words: page, column high and column low commands
//   (is_data = 0), then six glyph columns (is_data = 1), last set on the ninth.
//   The first word of a character passes through the sequencer state and
//   the output register before it is presented. Words leave by the
//   single-word output port; the next character is accepted on the cycle
//   its predecessor's ninth word is issued, so words flow without gaps. A
//   cursor load is accepted without a stall when the sequencer is free.
//   Reset (rst, synchronous): cursor returns to column 0, page 0 and both
//   channels go idle.
//   out_stall holds the output word and freezes the sequencer and font ROM;
//   in_stall stays high while a character's words are being issued, so it
//   holds through any output stall until the last word goes out.

module text_to_oled_byte_stream_top import t2o_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic       advance;
  logic       emit;
  seq_req_t   req;
  logic [7:0] rom_q;
  logic [7:0] cmd;
  logic       is_data;
  logic       last;

  assign advance = !out_valid || !out_stall;

  t2o_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .advance  (advance),
    .emit     (emit),
    .req      (req)
  );

  t2o_glyph_rom u_rom (
    .clk   (clk),
    .en    (advance && emit),
    .glyph (req.glyph),
    .gcol  (req.gcol),
    .q     (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      cmd     <= req.cmd;
      is_data <= req.is_data;
      last    <= req.last;
    end
  end

  assign out_data.out_byte = is_data ? rom_q : cmd;
  assign out_data.is_data  = is_data;
  assign out_data.last     = last;

endmodule
